[src/rjh_pkg.sv]
// ----------------------------------------------------------------------------
// rjh_pkg
// Shared types, constants and the sequencer program of the reprojection
// Jacobian block.
// ----------------------------------------------------------------------------
package rjh_pkg;

    // word format
    localparam int WORD_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int ACC_W   = 52;
    localparam int DIVN_W  = WORD_W + FRAC_W;
    localparam int SQRT_W  = 2 * WORD_W;
    localparam int WGT_W   = FRAC_W + 1;
    localparam int THR_W   = WORD_W - 1;
    localparam int POSE_N  = 12;
    localparam int POSE_AW = 4;
    localparam int PC_W    = 7;
    localparam int IN_W    = 200;
    localparam int OUT_W   = 312;

    localparam logic [WORD_W-1:0] W_MAX     = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] W_MIN     = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [WGT_W-1:0]  W_ONE     = {1'b1, {FRAC_W{1'b0}}};
    localparam logic [THR_W-1:0]  THR_RESET = THR_W'(655);

    // configuration register indexes
    localparam logic [1:0] CFG_ALPHA = 2'd0;
    localparam logic [1:0] CFG_BETA  = 2'd1;
    localparam logic [1:0] CFG_RHO   = 2'd2;
    localparam logic [1:0] CFG_THR   = 2'd3;

    // input kinds
    localparam logic KIND_POSE = 1'b0;
    localparam logic KIND_MEAS = 1'b1;

    typedef enum logic [4:0] {
        OP_CLR, OP_MUL, OP_ACCP, OP_SUBP, OP_ADD, OP_SUB, OP_SAT, OP_DIV,
        OP_DIVW, OP_SETS, OP_NSQRT, OP_NSQW, OP_BRANCH, OP_WDIV, OP_WSQRT,
        OP_WSQW, OP_DONE
    } t_op;

    typedef enum logic [3:0] {
        SRC_POSE, SRC_ALPHA, SRC_BETA, SRC_RHO, SRC_H0, SRC_H1, SRC_H2,
        SRC_C0, SRC_C1, SRC_C2, SRC_PR0, SRC_PR1, SRC_R0, SRC_R1,
        SRC_MU, SRC_MV
    } t_src;

    typedef enum logic [3:0] {
        DST_H0, DST_H1, DST_H2, DST_C0, DST_C1, DST_C2, DST_PR0, DST_PR1,
        DST_J0, DST_J1, DST_J2, DST_J3, DST_J4, DST_J5, DST_R0, DST_R1
    } t_dst;

    typedef struct packed {
        t_op                op;
        t_src               sa;
        t_src               sb;
        logic [POSE_AW-1:0] pa;
        t_dst               dst;
    } t_uop;

    typedef struct packed {
        logic pose_we;
        logic meas_take;
        logic uop_en;
        logic load_out;
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic unit_done;
        logic norm_le_thr;
        logic out_free;
    } t_stat;

    localparam logic [PC_W-1:0] PC_DONE = PC_W'(92);

    function automatic t_uop mk(input t_op op, input t_src sa, input t_src sb,
                                input int pa, input t_dst dst);
        t_uop u;
        u.op  = op;
        u.sa  = sa;
        u.sb  = sb;
        u.pa  = POSE_AW'(pa);
        u.dst = dst;
        return u;
    endfunction

    // sequencer program: one micro-op per step
    function automatic t_uop rom(input logic [PC_W-1:0] pc);
        t_uop u;
        u = mk(OP_DONE, SRC_POSE, SRC_POSE, 0, DST_H0);
        case (pc)
            // h = R*[alpha, beta, 1] + rho*t, one row at a time
            7'd0:  u = mk(OP_CLR,  SRC_POSE,  SRC_POSE,  0,  DST_H0);
            7'd1:  u = mk(OP_MUL,  SRC_POSE,  SRC_ALPHA, 0,  DST_H0);
            7'd2:  u = mk(OP_ACCP, SRC_POSE,  SRC_POSE,  0,  DST_H0);
            7'd3:  u = mk(OP_MUL,  SRC_POSE,  SRC_BETA,  1,  DST_H0);
            7'd4:  u = mk(OP_ACCP, SRC_POSE,  SRC_POSE,  0,  DST_H0);
            7'd5:  u = mk(OP_ADD,  SRC_POSE,  SRC_POSE,  2,  DST_H0);
            7'd6:  u = mk(OP_MUL,  SRC_POSE,  SRC_RHO,   3,  DST_H0);
            7'd7:  u = mk(OP_ACCP, SRC_POSE,  SRC_POSE,  0,  DST_H0);
            7'd8:  u = mk(OP_SAT,  SRC_POSE,  SRC_POSE,  0,  DST_H0);
            7'd9:  u = mk(OP_CLR,  SRC_POSE,  SRC_POSE,  0,  DST_H1);
            7'd10: u = mk(OP_MUL,  SRC_POSE,  SRC_ALPHA, 4,  DST_H1);
            7'd11: u = mk(OP_ACCP, SRC_POSE,  SRC_POSE,  0,  DST_H1);
            7'd12: u = mk(OP_MUL,  SRC_POSE,  SRC_BETA,  5,  DST_H1);
            7'd13: u = mk(OP_ACCP, SRC_POSE,  SRC_POSE,  0,  DST_H1);
            7'd14: u = mk(OP_ADD,  SRC_POSE,  SRC_POSE,  6,  DST_H1);
            7'd15: u = mk(OP_MUL,  SRC_POSE,  SRC_RHO,   7,  DST_H1);
            7'd16: u = mk(OP_ACCP, SRC_POSE,  SRC_POSE,  0,  DST_H1);
            7'd17: u = mk(OP_SAT,  SRC_POSE,  SRC_POSE,  0,  DST_H1);
            7'd18: u = mk(OP_CLR,  SRC_POSE,  SRC_POSE,  0,  DST_H2);
            7'd19: u = mk(OP_MUL,  SRC_POSE,  SRC_ALPHA, 8,  DST_H2);
            7'd20: u = mk(OP_ACCP, SRC_POSE,  SRC_POSE,  0,  DST_H2);
            7'd21: u = mk(OP_MUL,  SRC_POSE,  SRC_BETA,  9,  DST_H2);
            7'd22: u = mk(OP_ACCP, SRC_POSE,  SRC_POSE,  0,  DST_H2);
            7'd23: u = mk(OP_ADD,  SRC_POSE,  SRC_POSE,  10, DST_H2);
            7'd24: u = mk(OP_MUL,  SRC_POSE,  SRC_RHO,   11, DST_H2);
            7'd25: u = mk(OP_ACCP, SRC_POSE,  SRC_POSE,  0,  DST_H2);
            7'd26: u = mk(OP_SAT,  SRC_POSE,  SRC_POSE,  0,  DST_H2);
            // depth row of W over h2
            7'd27: u = mk(OP_DIV,  SRC_POSE,  SRC_H2,    8,  DST_C0);
            7'd28: u = mk(OP_DIVW, SRC_POSE,  SRC_POSE,  0,  DST_C0);
            7'd29: u = mk(OP_SAT,  SRC_POSE,  SRC_POSE,  0,  DST_C0);
            7'd30: u = mk(OP_DIV,  SRC_POSE,  SRC_H2,    9,  DST_C1);
            7'd31: u = mk(OP_DIVW, SRC_POSE,  SRC_POSE,  0,  DST_C1);
            7'd32: u = mk(OP_SAT,  SRC_POSE,  SRC_POSE,  0,  DST_C1);
            7'd33: u = mk(OP_DIV,  SRC_POSE,  SRC_H2,    11, DST_C2);
            7'd34: u = mk(OP_DIVW, SRC_POSE,  SRC_POSE,  0,  DST_C2);
            7'd35: u = mk(OP_SAT,  SRC_POSE,  SRC_POSE,  0,  DST_C2);
            // u row: prediction, Jacobian, residual
            7'd36: u = mk(OP_DIV,  SRC_H0,    SRC_H2,    0,  DST_PR0);
            7'd37: u = mk(OP_DIVW, SRC_POSE,  SRC_POSE,  0,  DST_PR0);
            7'd38: u = mk(OP_SAT,  SRC_POSE,  SRC_POSE,  0,  DST_PR0);
            7'd39: u = mk(OP_DIV,  SRC_POSE,  SRC_H2,    0,  DST_J0);
            7'd40: u = mk(OP_DIVW, SRC_POSE,  SRC_POSE,  0,  DST_J0);
            7'd41: u = mk(OP_MUL,  SRC_PR0,   SRC_C0,    0,  DST_J0);
            7'd42: u = mk(OP_SUBP, SRC_POSE,  SRC_POSE,  0,  DST_J0);
            7'd43: u = mk(OP_SAT,  SRC_POSE,  SRC_POSE,  0,  DST_J0);
            7'd44: u = mk(OP_DIV,  SRC_POSE,  SRC_H2,    1,  DST_J1);
            7'd45: u = mk(OP_DIVW, SRC_POSE,  SRC_POSE,  0,  DST_J1);
            7'd46: u = mk(OP_MUL,  SRC_PR0,   SRC_C1,    0,  DST_J1);
            7'd47: u = mk(OP_SUBP, SRC_POSE,  SRC_POSE,  0,  DST_J1);
            7'd48: u = mk(OP_SAT,  SRC_POSE,  SRC_POSE,  0,  DST_J1);
            7'd49: u = mk(OP_DIV,  SRC_POSE,  SRC_H2,    3,  DST_J2);
            7'd50: u = mk(OP_DIVW, SRC_POSE,  SRC_POSE,  0,  DST_J2);
            7'd51: u = mk(OP_MUL,  SRC_PR0,   SRC_C2,    0,  DST_J2);
            7'd52: u = mk(OP_SUBP, SRC_POSE,  SRC_POSE,  0,  DST_J2);
            7'd53: u = mk(OP_SAT,  SRC_POSE,  SRC_POSE,  0,  DST_J2);
            7'd54: u = mk(OP_CLR,  SRC_POSE,  SRC_POSE,  0,  DST_R0);
            7'd55: u = mk(OP_ADD,  SRC_PR0,   SRC_POSE,  0,  DST_R0);
            7'd56: u = mk(OP_SUB,  SRC_MU,    SRC_POSE,  0,  DST_R0);
            7'd57: u = mk(OP_SAT,  SRC_POSE,  SRC_POSE,  0,  DST_R0);
            // v row
            7'd58: u = mk(OP_DIV,  SRC_H1,    SRC_H2,    0,  DST_PR1);
            7'd59: u = mk(OP_DIVW, SRC_POSE,  SRC_POSE,  0,  DST_PR1);
            7'd60: u = mk(OP_SAT,  SRC_POSE,  SRC_POSE,  0,  DST_PR1);
            7'd61: u = mk(OP_DIV,  SRC_POSE,  SRC_H2,    4,  DST_J3);
            7'd62: u = mk(OP_DIVW, SRC_POSE,  SRC_POSE,  0,  DST_J3);
            7'd63: u = mk(OP_MUL,  SRC_PR1,   SRC_C0,    0,  DST_J3);
            7'd64: u = mk(OP_SUBP, SRC_POSE,  SRC_POSE,  0,  DST_J3);
            7'd65: u = mk(OP_SAT,  SRC_POSE,  SRC_POSE,  0,  DST_J3);
            7'd66: u = mk(OP_DIV,  SRC_POSE,  SRC_H2,    5,  DST_J4);
            7'd67: u = mk(OP_DIVW, SRC_POSE,  SRC_POSE,  0,  DST_J4);
            7'd68: u = mk(OP_MUL,  SRC_PR1,   SRC_C1,    0,  DST_J4);
            7'd69: u = mk(OP_SUBP, SRC_POSE,  SRC_POSE,  0,  DST_J4);
            7'd70: u = mk(OP_SAT,  SRC_POSE,  SRC_POSE,  0,  DST_J4);
            7'd71: u = mk(OP_DIV,  SRC_POSE,  SRC_H2,    7,  DST_J5);
            7'd72: u = mk(OP_DIVW, SRC_POSE,  SRC_POSE,  0,  DST_J5);
            7'd73: u = mk(OP_MUL,  SRC_PR1,   SRC_C2,    0,  DST_J5);
            7'd74: u = mk(OP_SUBP, SRC_POSE,  SRC_POSE,  0,  DST_J5);
            7'd75: u = mk(OP_SAT,  SRC_POSE,  SRC_POSE,  0,  DST_J5);
            7'd76: u = mk(OP_CLR,  SRC_POSE,  SRC_POSE,  0,  DST_R1);
            7'd77: u = mk(OP_ADD,  SRC_PR1,   SRC_POSE,  0,  DST_R1);
            7'd78: u = mk(OP_SUB,  SRC_MV,    SRC_POSE,  0,  DST_R1);
            7'd79: u = mk(OP_SAT,  SRC_POSE,  SRC_POSE,  0,  DST_R1);
            // squared error, norm and robust weight
            7'd80: u = mk(OP_CLR,  SRC_POSE,  SRC_POSE,  0,  DST_H0);
            7'd81: u = mk(OP_MUL,  SRC_R0,    SRC_R0,    0,  DST_H0);
            7'd82: u = mk(OP_ACCP, SRC_POSE,  SRC_POSE,  0,  DST_H0);
            7'd83: u = mk(OP_MUL,  SRC_R1,    SRC_R1,    0,  DST_H0);
            7'd84: u = mk(OP_ACCP, SRC_POSE,  SRC_POSE,  0,  DST_H0);
            7'd85: u = mk(OP_SETS, SRC_POSE,  SRC_POSE,  0,  DST_H0);
            7'd86: u = mk(OP_NSQRT, SRC_POSE, SRC_POSE,  0,  DST_H0);
            7'd87: u = mk(OP_NSQW, SRC_POSE,  SRC_POSE,  0,  DST_H0);
            7'd88: u = mk(OP_BRANCH, SRC_POSE, SRC_POSE, 0,  DST_H0);
            7'd89: u = mk(OP_WDIV, SRC_POSE,  SRC_POSE,  0,  DST_H0);
            7'd90: u = mk(OP_WSQRT, SRC_POSE, SRC_POSE,  0,  DST_H0);
            7'd91: u = mk(OP_WSQW, SRC_POSE,  SRC_POSE,  0,  DST_H0);
            default: u = mk(OP_DONE, SRC_POSE, SRC_POSE, 0,  DST_H0);
        endcase
        return u;
    endfunction

    // saturate an accumulator value to the signed word
    function automatic logic [WORD_W-1:0] sat_w(input logic [ACC_W-1:0] x);
        logic [WORD_W-1:0] r;
        if ((&x[ACC_W-1:WORD_W-1]) || !(|x[ACC_W-1:WORD_W-1])) begin
            r = x[WORD_W-1:0];
        end else if (x[ACC_W-1]) begin
            r = W_MIN;
        end else begin
            r = W_MAX;
        end
        return r;
    endfunction

endpackage

[src/reprojection_jacobian_huber.sv]
// ----------------------------------------------------------------------------
// reprojection_jacobian_huber
// Inverse-depth reprojection Jacobian with Huber weight, Q16.16 fixed point.
// ----------------------------------------------------------------------------
//  channel   direction  transaction
//  s_axis    in         pose row (tuser kind 0) or measurement (kind 1)
//  m_axis    out        Jacobian, residual, weight, squared error, flag
//  cfg       in         write of alpha, beta, rho or Huber threshold
//
//  A pose row is taken only while idle and yields no result.
//  A measurement runs a micro-op program of up to 93 steps; it waits for the
//  divider on each division (11 of them, 12 when the weight is computed) and
//  for the square root unit on each root (one, or two past the threshold),
//  and no new item is taken until its result is loaded into the output.
//  The shared divider resolves one quotient bit per cycle.
//  Reset is synchronous active low; no clearing pass is needed.
//  A finished result holds in the output register while the next item is
//  taken; the sequencer stalls at its last step only if that register is
//  still full.
// ----------------------------------------------------------------------------
module reprojection_jacobian_huber (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // pose_row, rot_col0, rot_col1, rot_col2, trans_elem, meas_u, meas_v
    input  logic [rjh_pkg::IN_W-1:0]      s_axis_tdata,
    // kind
    input  logic [0:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // jac_u_alpha, jac_u_beta, jac_u_rho, jac_v_alpha, jac_v_beta, jac_v_rho,
    // resid_u, resid_v, huber_weight, squared_error, depth_bad
    output logic [rjh_pkg::OUT_W-1:0]     m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [rjh_pkg::WORD_W-1:0]    i_cfg_wdata
);

    rjh_pkg::t_cmd  cmd;
    rjh_pkg::t_stat stat;

    rjh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser[0]),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rjh_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

[src/rjh_div.sv]
// ----------------------------------------------------------------------------
// rjh_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rjh_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rjh_pkg::DIVN_W-1:0]    i_num,
    input  logic [rjh_pkg::WORD_W-1:0]    i_den,
    output logic [rjh_pkg::DIVN_W-1:0]    o_quo,
    output logic                          o_done
);

    localparam int CNT_W = $clog2(rjh_pkg::DIVN_W);
    localparam int W     = rjh_pkg::WORD_W;
    localparam int N     = rjh_pkg::DIVN_W;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0]     r_rem;
    logic [N-1:0]     r_quo;
    logic [W-1:0]     r_den;
    logic [W:0]       rem_sh;
    logic [W+1:0]     diff;
    logic             fits;

    // trial subtract of the shifted remainder
    assign rem_sh = {r_rem, r_quo[N-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_den};
    assign fits   = !diff[W+1];

    // sequence control
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(N - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? diff[W-1:0] : rem_sh[W-1:0];
            r_quo <= {r_quo[N-2:0], fits};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

[src/rjh_sqrt.sv]
// ----------------------------------------------------------------------------
// rjh_sqrt
// Integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module rjh_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rjh_pkg::SQRT_W-1:0]    i_rad,
    output logic [rjh_pkg::WORD_W-1:0]    o_root,
    output logic                          o_done
);

    localparam int W     = rjh_pkg::WORD_W;
    localparam int R     = rjh_pkg::SQRT_W;
    localparam int CNT_W = $clog2(W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [R-1:0]     r_rad;
    logic [W+1:0]     r_rem;
    logic [W-1:0]     r_root;
    logic [W+3:0]     rem4;
    logic [W+3:0]     trial;
    logic [W+4:0]     diff;
    logic             fits;

    // trial subtract of 4*root+1
    assign rem4  = {r_rem, r_rad[R-1:R-2]};
    assign trial = {2'b00, r_root, 2'b01};
    assign diff  = {1'b0, rem4} - {1'b0, trial};
    assign fits  = !diff[W+4];

    // sequence control
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // remainder, root and radicand shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[R-3:0], 2'b00};
            r_rem  <= fits ? diff[W+1:0] : rem4[W+1:0];
            r_root <= {r_root[W-2:0], fits};
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

[src/rjh_dp.sv]
// ----------------------------------------------------------------------------
// rjh_dp
// Datapath: pose store, configuration, multiplier, accumulator, divider,
// square root and output register.
// ----------------------------------------------------------------------------
module rjh_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rjh_pkg::t_cmd                 i_cmd,
    output rjh_pkg::t_stat                o_stat,
    input  logic [rjh_pkg::IN_W-1:0]      i_in_data,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [rjh_pkg::WORD_W-1:0]    i_cfg_wdata,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rjh_pkg::OUT_W-1:0]     o_out_data
);

    localparam int W = rjh_pkg::WORD_W;
    localparam int F = rjh_pkg::FRAC_W;
    localparam int A = rjh_pkg::ACC_W;
    localparam int N = rjh_pkg::DIVN_W;

    // configuration
    logic [W-1:0]              r_alpha, r_beta, r_rho;
    logic [rjh_pkg::THR_W-1:0] r_thr;

    // pose store and working registers
    logic [W-1:0]              r_pose [rjh_pkg::POSE_N];
    logic [W-1:0]              r_h    [3];
    logic [W-1:0]              r_c    [3];
    logic [W-1:0]              r_pr   [2];
    logic [W-1:0]              r_jac  [6];
    logic [W-1:0]              r_res  [2];
    logic [W-1:0]              r_mu, r_mv;
    logic signed [2*W-1:0]     r_prod;
    logic [A-1:0]              r_acc;
    logic [N-1:0]              r_s;
    logic [W-1:0]              r_norm;
    logic [rjh_pkg::WGT_W-1:0] r_weight;
    logic                      r_neg, r_a_pos, r_a_neg, r_b_zero;
    logic                      r_ovalid;
    logic [rjh_pkg::OUT_W-1:0] r_odata;

    rjh_pkg::t_uop             u;
    logic [W-1:0]              src_a, src_b;
    logic [W-1:0]              mag_a, mag_b;
    logic [2*W-F-1:0]          prod_fl;
    logic [W-1:0]              q_fix;
    logic                      div_start, sqrt_start;
    logic [N-1:0]              div_num;
    logic [W-1:0]              div_den;
    logic [N-1:0]              div_quo;
    logic                      div_done;
    logic [rjh_pkg::SQRT_W-1:0] sqrt_rad;
    logic [W-1:0]              sqrt_root;
    logic                      sqrt_done;
    logic [1:0]                in_row;
    logic [W-1:0]              sq_err;
    logic                      depth_bad;

    assign u      = i_cmd.uop;
    assign in_row = i_in_data[1:0];

    // operand selection
    function automatic logic [W-1:0] pick(input rjh_pkg::t_src s,
                                          input logic [W-1:0] pose_v);
        logic [W-1:0] v;
        case (s)
            rjh_pkg::SRC_POSE:  v = pose_v;
            rjh_pkg::SRC_ALPHA: v = r_alpha;
            rjh_pkg::SRC_BETA:  v = r_beta;
            rjh_pkg::SRC_RHO:   v = r_rho;
            rjh_pkg::SRC_H0:    v = r_h[0];
            rjh_pkg::SRC_H1:    v = r_h[1];
            rjh_pkg::SRC_H2:    v = r_h[2];
            rjh_pkg::SRC_C0:    v = r_c[0];
            rjh_pkg::SRC_C1:    v = r_c[1];
            rjh_pkg::SRC_C2:    v = r_c[2];
            rjh_pkg::SRC_PR0:   v = r_pr[0];
            rjh_pkg::SRC_PR1:   v = r_pr[1];
            rjh_pkg::SRC_R0:    v = r_res[0];
            rjh_pkg::SRC_R1:    v = r_res[1];
            rjh_pkg::SRC_MU:    v = r_mu;
            rjh_pkg::SRC_MV:    v = r_mv;
            default:            v = pose_v;
        endcase
        return v;
    endfunction

    assign src_a = pick(u.sa, r_pose[u.pa]);
    assign src_b = pick(u.sb, r_pose[u.pa]);
    assign mag_a = src_a[W-1] ? (~src_a + 1'b1) : src_a;
    assign mag_b = src_b[W-1] ? (~src_b + 1'b1) : src_b;

    // floored product
    assign prod_fl = r_prod[2*W-1:F];

    // sign fixup and saturation of a signed quotient
    always_comb begin
        if (r_b_zero) begin
            q_fix = r_a_pos ? rjh_pkg::W_MAX : (r_a_neg ? rjh_pkg::W_MIN : '0);
        end else if (|div_quo[N-1:W-1]) begin
            q_fix = r_neg ? rjh_pkg::W_MIN : rjh_pkg::W_MAX;
        end else if (r_neg) begin
            q_fix = ~div_quo[W-1:0] + 1'b1;
        end else begin
            q_fix = div_quo[W-1:0];
        end
    end

    // iterative unit commands
    always_comb begin
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        div_num    = {mag_a, {F{1'b0}}};
        div_den    = mag_b;
        sqrt_rad   = {r_s, {F{1'b0}}};
        if (i_cmd.uop_en) begin
            case (u.op)
                rjh_pkg::OP_DIV: begin
                    div_start = 1'b1;
                end
                rjh_pkg::OP_WDIV: begin
                    div_start = 1'b1;
                    div_num   = {r_thr, 1'b0, {F{1'b0}}};
                    div_den   = r_norm;
                end
                rjh_pkg::OP_NSQRT: begin
                    sqrt_start = 1'b1;
                end
                rjh_pkg::OP_WSQRT: begin
                    sqrt_start = 1'b1;
                    sqrt_rad   = {div_quo, {F{1'b0}}};
                end
                default: begin
                    div_start = 1'b0;
                end
            endcase
        end
    end

    rjh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    rjh_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (sqrt_rad),
        .o_root  (sqrt_root),
        .o_done  (sqrt_done)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= '0;
            r_beta  <= '0;
            r_rho   <= '0;
            r_thr   <= rjh_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rjh_pkg::CFG_ALPHA: r_alpha <= i_cfg_wdata;
                rjh_pkg::CFG_BETA:  r_beta  <= i_cfg_wdata;
                rjh_pkg::CFG_RHO:   r_rho   <= i_cfg_wdata;
                rjh_pkg::CFG_THR:   r_thr   <= i_cfg_wdata[rjh_pkg::THR_W-1:0];
                default:            r_thr   <= r_thr;
            endcase
        end
    end

    // pose rows: drop row index three
    always_ff @(posedge i_clk) begin
        if (i_cmd.pose_we && in_row != 2'd3) begin
            r_pose[{in_row, 2'd0}] <= i_in_data[2+W-1:2];
            r_pose[{in_row, 2'd1}] <= i_in_data[2+2*W-1:2+W];
            r_pose[{in_row, 2'd2}] <= i_in_data[2+3*W-1:2+2*W];
            r_pose[{in_row, 2'd3}] <= i_in_data[2+4*W-1:2+3*W];
        end
    end

    // micro-op execution
    always_ff @(posedge i_clk) begin
        if (i_cmd.meas_take) begin
            r_mu <= i_in_data[2+5*W-1:2+4*W];
            r_mv <= i_in_data[2+6*W-1:2+5*W];
        end
        if (i_cmd.uop_en) begin
            case (u.op)
                rjh_pkg::OP_CLR:  r_acc  <= '0;
                rjh_pkg::OP_MUL:  r_prod <= signed'(src_a) * signed'(src_b);
                rjh_pkg::OP_ACCP: r_acc  <= r_acc + A'(signed'(prod_fl));
                rjh_pkg::OP_SUBP: r_acc  <= r_acc - A'(signed'(prod_fl));
                rjh_pkg::OP_ADD:  r_acc  <= r_acc + A'(signed'(src_a));
                rjh_pkg::OP_SUB:  r_acc  <= r_acc - A'(signed'(src_a));
                rjh_pkg::OP_SAT: begin
                    case (u.dst)
                        rjh_pkg::DST_H0:  r_h[0]   <= rjh_pkg::sat_w(r_acc);
                        rjh_pkg::DST_H1:  r_h[1]   <= rjh_pkg::sat_w(r_acc);
                        rjh_pkg::DST_H2:  r_h[2]   <= rjh_pkg::sat_w(r_acc);
                        rjh_pkg::DST_C0:  r_c[0]   <= rjh_pkg::sat_w(r_acc);
                        rjh_pkg::DST_C1:  r_c[1]   <= rjh_pkg::sat_w(r_acc);
                        rjh_pkg::DST_C2:  r_c[2]   <= rjh_pkg::sat_w(r_acc);
                        rjh_pkg::DST_PR0: r_pr[0]  <= rjh_pkg::sat_w(r_acc);
                        rjh_pkg::DST_PR1: r_pr[1]  <= rjh_pkg::sat_w(r_acc);
                        rjh_pkg::DST_J0:  r_jac[0] <= rjh_pkg::sat_w(r_acc);
                        rjh_pkg::DST_J1:  r_jac[1] <= rjh_pkg::sat_w(r_acc);
                        rjh_pkg::DST_J2:  r_jac[2] <= rjh_pkg::sat_w(r_acc);
                        rjh_pkg::DST_J3:  r_jac[3] <= rjh_pkg::sat_w(r_acc);
                        rjh_pkg::DST_J4:  r_jac[4] <= rjh_pkg::sat_w(r_acc);
                        rjh_pkg::DST_J5:  r_jac[5] <= rjh_pkg::sat_w(r_acc);
                        rjh_pkg::DST_R0:  r_res[0] <= rjh_pkg::sat_w(r_acc);
                        rjh_pkg::DST_R1:  r_res[1] <= rjh_pkg::sat_w(r_acc);
                        default:          r_h[0]   <= rjh_pkg::sat_w(r_acc);
                    endcase
                end
                rjh_pkg::OP_DIV: begin
                    r_neg    <= src_a[W-1] ^ src_b[W-1];
                    r_a_pos  <= !src_a[W-1] && (src_a != '0);
                    r_a_neg  <= src_a[W-1];
                    r_b_zero <= (src_b == '0);
                end
                rjh_pkg::OP_DIVW:   r_acc  <= A'(signed'(q_fix));
                rjh_pkg::OP_SETS:   r_s    <= r_acc[N-1:0];
                rjh_pkg::OP_NSQW:   r_norm <= sqrt_root;
                rjh_pkg::OP_BRANCH: begin
                    if (o_stat.norm_le_thr) begin
                        r_weight <= rjh_pkg::W_ONE;
                    end
                end
                rjh_pkg::OP_WSQW: begin
                    r_weight <= (sqrt_root > W'(rjh_pkg::W_ONE)) ? rjh_pkg::W_ONE
                                : sqrt_root[rjh_pkg::WGT_W-1:0];
                end
                default: r_acc <= r_acc;
            endcase
        end
    end

    // result fields
    assign sq_err    = (|r_s[N-1:W]) ? {W{1'b1}} : r_s[W-1:0];
    assign depth_bad = (r_h[2] == '0);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_odata <= {6'd0, depth_bad, sq_err, r_weight, r_res[1], r_res[0],
                        r_jac[5], r_jac[4], r_jac[3], r_jac[2], r_jac[1], r_jac[0]};
        end
    end

    assign o_stat.unit_done   = div_done | sqrt_done;
    assign o_stat.norm_le_thr = (r_norm <= {1'b0, r_thr});
    assign o_stat.out_free    = !r_ovalid || i_out_ready;
    assign o_out_valid        = r_ovalid;
    assign o_out_data         = r_odata;

endmodule

[src/rjh_ctrl.sv]
// ----------------------------------------------------------------------------
// rjh_ctrl
// Controller: input handshake and the micro-op sequencer.
// ----------------------------------------------------------------------------
module rjh_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_kind,
    output logic           o_in_ready,
    input  rjh_pkg::t_stat i_stat,
    output rjh_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    t_state                    r_state, n_state;
    logic [rjh_pkg::PC_W-1:0]  r_pc, n_pc;
    rjh_pkg::t_uop             uop;
    logic                      is_unit;

    assign uop = rjh_pkg::rom(r_pc);

    always_comb begin
        is_unit = uop.op inside {rjh_pkg::OP_DIV, rjh_pkg::OP_WDIV,
                                 rjh_pkg::OP_NSQRT, rjh_pkg::OP_WSQRT};
    end

    // commands to the datapath
    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cmd.pose_we   = o_in_ready && i_in_valid && (i_in_kind == rjh_pkg::KIND_POSE);
    assign o_cmd.meas_take = o_in_ready && i_in_valid && (i_in_kind == rjh_pkg::KIND_MEAS);
    assign o_cmd.uop_en    = (r_state == S_RUN);
    assign o_cmd.load_out  = (r_state == S_RUN) && (uop.op == rjh_pkg::OP_DONE)
                             && i_stat.out_free;
    assign o_cmd.uop       = uop;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.meas_take) begin
                    n_state = S_RUN;
                    n_pc    = '0;
                end
            end
            S_RUN: begin
                if (is_unit) begin
                    n_state = S_WAIT;
                end else if (uop.op == rjh_pkg::OP_BRANCH) begin
                    n_pc = i_stat.norm_le_thr ? rjh_pkg::PC_DONE : r_pc + 1'b1;
                end else if (uop.op == rjh_pkg::OP_DONE) begin
                    if (i_stat.out_free) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_pc = r_pc + 1'b1;
                end
            end
            S_WAIT: begin
                if (i_stat.unit_done) begin
                    n_state = S_RUN;
                    n_pc    = r_pc + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

`ifndef SYNTHESIS
    a_unit_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && is_unit) |=> (r_state == S_WAIT))
        else $error("unit start did not enter wait");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_stat.out_free)
        else $error("output loaded while occupied");
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_pc <= rjh_pkg::PC_DONE))
        else $error("sequencer ran past the program");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> !o_cmd.meas_take && !o_cmd.pose_we)
        else $error("input taken while busy");
`endif

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the reprojection Jacobian block: loads camera poses,
// streams measurements under several estimate and threshold settings, and
// compares every result field against a bit-accurate fixed-point predictor,
// or against fixed expected values for the typed directed measurements.
module tb;

    localparam int IDLE_WAIT  = 800;
    localparam int STALL_MAX  = 20000;
    localparam int RAND_ITEMS = 150;

    // s_axis tdata fields, lowest bits last
    typedef struct packed {
        logic [5:0]  pad;
        logic [31:0] meas_v;
        logic [31:0] meas_u;
        logic [31:0] trans_elem;
        logic [31:0] rot_col2;
        logic [31:0] rot_col1;
        logic [31:0] rot_col0;
        logic [1:0]  pose_row;
    } t_item;

    // m_axis tdata fields, lowest bits last
    typedef struct packed {
        logic [5:0]  pad;
        logic        depth_bad;
        logic [31:0] squared_error;
        logic [16:0] huber_weight;
        logic [31:0] resid_v;
        logic [31:0] resid_u;
        logic [31:0] jac_v_rho;
        logic [31:0] jac_v_beta;
        logic [31:0] jac_v_alpha;
        logic [31:0] jac_u_rho;
        logic [31:0] jac_u_beta;
        logic [31:0] jac_u_alpha;
    } t_res;

    typedef struct {
        logic  kind;
        t_item item;
        bit    typed;
        logic  typed_bad;
    } t_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [rjh_pkg::IN_W-1:0]   s_axis_tdata = '0;
    logic [0:0]                 s_axis_tuser = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [rjh_pkg::OUT_W-1:0]  m_axis_tdata;
    logic                       i_cfg_we = 1'b0;
    logic [1:0]                 i_cfg_idx = '0;
    logic [rjh_pkg::WORD_W-1:0] i_cfg_wdata = '0;

    reprojection_jacobian_huber i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // predictor state: pose store and estimate registers
    longint          pose_mem[12];
    longint          est_a, est_b, est_r;
    longint unsigned huber_eps;

    t_res   result_q[$];
    t_row   dir_tab[$];
    int     fail_cnt = 0;
    int     idle_cnt = 0;

    function automatic longint sat_word(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return (a * b) >>> rjh_pkg::FRAC_W;
    endfunction

    function automatic longint fx_div(input longint a, input longint b);
        longint unsigned ma, mb, q;
        bit neg;
        if (b == 0) return (a > 0) ? 64'sd2147483647 : ((a < 0) ? -64'sd2147483648 : 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        neg = (a < 0) != (b < 0);
        q   = (ma << rjh_pkg::FRAC_W) / mb;
        if (q > 64'd2147483647) return neg ? -64'sd2147483648 : 64'sd2147483647;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // evaluate one measurement against the stored pose
    function automatic t_res eval_meas(input t_item it);
        longint h[3], c[3], w[3], jac[2][3], pred[2], res[2], meas[2];
        longint unsigned s, nrm, wgt, q;
        t_res o;
        meas[0] = longint'($signed(it.meas_u));
        meas[1] = longint'($signed(it.meas_v));
        for (int i = 0; i < 3; i++)
            h[i] = sat_word(fx_mul(pose_mem[4*i], est_a) + fx_mul(pose_mem[4*i+1], est_b)
                            + pose_mem[4*i+2] + fx_mul(pose_mem[4*i+3], est_r));
        c[0] = fx_div(pose_mem[8], h[2]);
        c[1] = fx_div(pose_mem[9], h[2]);
        c[2] = fx_div(pose_mem[11], h[2]);
        for (int i = 0; i < 2; i++) begin
            w[0] = pose_mem[4*i];
            w[1] = pose_mem[4*i+1];
            w[2] = pose_mem[4*i+3];
            pred[i] = fx_div(h[i], h[2]);
            for (int k = 0; k < 3; k++)
                jac[i][k] = sat_word(fx_div(w[k], h[2]) - fx_mul(pred[i], c[k]));
            res[i] = sat_word(pred[i] - meas[i]);
        end
        s   = fx_mul(res[0], res[0]) + fx_mul(res[1], res[1]);
        nrm = int_sqrt(s << rjh_pkg::FRAC_W);
        if (nrm <= huber_eps) begin
            wgt = 64'd1 << rjh_pkg::FRAC_W;
        end else begin
            q   = ((2 * huber_eps) << rjh_pkg::FRAC_W) / nrm;
            wgt = int_sqrt(q << rjh_pkg::FRAC_W);
            if (wgt > (64'd1 << rjh_pkg::FRAC_W)) wgt = 64'd1 << rjh_pkg::FRAC_W;
        end
        o = '0;
        o.jac_u_alpha   = jac[0][0][31:0];
        o.jac_u_beta    = jac[0][1][31:0];
        o.jac_u_rho     = jac[0][2][31:0];
        o.jac_v_alpha   = jac[1][0][31:0];
        o.jac_v_beta    = jac[1][1][31:0];
        o.jac_v_rho     = jac[1][2][31:0];
        o.resid_u       = res[0][31:0];
        o.resid_v       = res[1][31:0];
        o.huber_weight  = wgt[16:0];
        o.squared_error = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
        o.depth_bad     = (h[2] == 0);
        return o;
    endfunction

    // update the pose store or queue the expected result of one transaction
    task automatic absorb_item(input logic kind, input t_item it, input bit typed,
                               input logic typed_bad);
        t_res e;
        if (kind == rjh_pkg::KIND_POSE) begin
            if (it.pose_row < 3) begin
                pose_mem[4*it.pose_row]   = longint'($signed(it.rot_col0));
                pose_mem[4*it.pose_row+1] = longint'($signed(it.rot_col1));
                pose_mem[4*it.pose_row+2] = longint'($signed(it.rot_col2));
                pose_mem[4*it.pose_row+3] = longint'($signed(it.trans_elem));
            end
        end else begin
            e = eval_meas(it);
            if (typed) begin
                e = '0;
                e.huber_weight = rjh_pkg::W_ONE;
                e.depth_bad    = typed_bad;
            end
            result_q.insert(result_q.size(), e);
        end
    endtask

    // drive one transaction after a random gap and wait for acceptance
    task automatic send_item(input logic kind, input t_item it, input bit typed,
                             input logic typed_bad);
        int gap;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it;
        s_axis_tuser  <= kind;
        forever begin
            @(posedge i_clk);
            if (s_axis_tready) break;
        end
        absorb_item(kind, it, typed, typed_bad);
    endtask

    // hold the sender until every result is back and the block is quiet
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_estimate(input logic [31:0] a, input logic [31:0] b,
                                  input logic [31:0] r, input logic [31:0] thr);
        logic [31:0] vals[4];
        vals = '{a, b, r, thr};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= 2'(i);
            i_cfg_wdata <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        est_a     = longint'($signed(a));
        est_b     = longint'($signed(b));
        est_r     = longint'($signed(r));
        huber_eps = thr[30:0];
    endtask

    function automatic logic [31:0] rand_word();
        if ($urandom_range(0, 9) < 7) return 32'($signed($urandom_range(0, 262143)) - 131072);
        return $urandom;
    endfunction

    function automatic t_item rand_item(input logic [1:0] row);
        t_item it;
        it            = '0;
        it.pose_row   = row;
        it.rot_col0   = rand_word();
        it.rot_col1   = rand_word();
        it.rot_col2   = rand_word();
        it.trans_elem = rand_word();
        it.meas_u     = rand_word();
        it.meas_v     = rand_word();
        return it;
    endfunction

    task automatic add_row(input logic kind, input logic [1:0] row, input logic [31:0] a,
                           input logic [31:0] b, input logic [31:0] c, input logic [31:0] d,
                           input logic [31:0] u, input logic [31:0] v, input bit typed,
                           input logic typed_bad);
        t_row r;
        r.item = '0;
        r.kind = kind;
        r.item.pose_row = row;
        r.item.rot_col0 = a;
        r.item.rot_col1 = b;
        r.item.rot_col2 = c;
        r.item.trans_elem = d;
        r.item.meas_u = u;
        r.item.meas_v = v;
        r.typed = typed;
        r.typed_bad = typed_bad;
        dir_tab.insert(dir_tab.size(), r);
    endtask

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        if (got !== want) begin
            $display("mismatch %s: got %h expected %h", field, got, want);
            fail_cnt++;
        end
    endtask

    // receive results with random stalls and check them in order
    initial begin : result_side
        int   stall;
        t_res got, want;
        forever begin
            stall = $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            forever begin
                @(posedge i_clk);
                if (m_axis_tvalid && i_rst_n) break;
            end
            got = m_axis_tdata;
            if (result_q.size() == 0) begin
                report("unexpected result", 32'd1, 32'd0);
            end else begin
                want = result_q.pop_front();
                report("jac_u_alpha", got.jac_u_alpha, want.jac_u_alpha);
                report("jac_u_beta", got.jac_u_beta, want.jac_u_beta);
                report("jac_u_rho", got.jac_u_rho, want.jac_u_rho);
                report("jac_v_alpha", got.jac_v_alpha, want.jac_v_alpha);
                report("jac_v_beta", got.jac_v_beta, want.jac_v_beta);
                report("jac_v_rho", got.jac_v_rho, want.jac_v_rho);
                report("resid_u", got.resid_u, want.resid_u);
                report("resid_v", got.resid_v, want.resid_v);
                report("huber_weight", 32'(got.huber_weight), 32'(want.huber_weight));
                report("squared_error", got.squared_error, want.squared_error);
                report("depth_bad", 32'(got.depth_bad), 32'(want.depth_bad));
            end
        end
    end

    // end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > STALL_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic [31:0] cfg_set[6][4];
        int          pick;
        est_a = 0;
        est_b = 0;
        est_r = 0;
        huber_eps = 655;
        foreach (pose_mem[i]) pose_mem[i] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero pose, identity depth row, extremes, ignored row three
        add_row(rjh_pkg::KIND_POSE, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
        add_row(rjh_pkg::KIND_POSE, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(rjh_pkg::KIND_POSE, 2, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(rjh_pkg::KIND_MEAS, 0, 0, 0, 0, 0, 0, 0, 1, 1);
        add_row(rjh_pkg::KIND_MEAS, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
        add_row(rjh_pkg::KIND_POSE, 2, 0, 0, 32'h0001_0000, 0, 0, 0, 0, 0);
        add_row(rjh_pkg::KIND_MEAS, 0, 0, 0, 0, 0, 0, 0, 1, 0);
        add_row(rjh_pkg::KIND_MEAS, 0, 0, 0, 0, 0, 32'h0000_8000, 32'hFFFF_8000, 0, 0);
        add_row(rjh_pkg::KIND_POSE, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 0, 0, 0, 0);
        add_row(rjh_pkg::KIND_POSE, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 0, 0, 0, 0);
        add_row(rjh_pkg::KIND_MEAS, 0, 0, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        add_row(rjh_pkg::KIND_POSE, 2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF,
                0, 0, 0, 0);
        add_row(rjh_pkg::KIND_MEAS, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(rjh_pkg::KIND_POSE, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
        add_row(rjh_pkg::KIND_MEAS, 0, 0, 0, 0, 0, 32'h0000_0100, 32'hFFFF_FF00, 0, 0);
        add_row(rjh_pkg::KIND_POSE, 2, 32'h0000_1000, 32'hFFFF_F000, 32'h0002_0000,
                32'h0000_4000, 0, 0, 0, 0);
        add_row(rjh_pkg::KIND_MEAS, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0000, 0, 0);
        foreach (dir_tab[i])
            send_item(dir_tab[i].kind, dir_tab[i].item, dir_tab[i].typed, dir_tab[i].typed_bad);

        // random phases, each under its own estimate and threshold
        cfg_set = '{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
                    '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000},
                    '{32'h0000_8000, 32'hFFFF_C000, 32'h0000_4000, 32'h0000_028F},
                    '{32'h0, 32'h0, 32'h0, 32'h8000_0010},
                    '{$urandom, $urandom, $urandom, $urandom},
                    '{rand_word(), rand_word(), rand_word(), 32'($urandom_range(0, 200000))}};
        for (int p = 0; p < 6; p++) begin
            drain_results();
            write_estimate(cfg_set[p][0], cfg_set[p][1], cfg_set[p][2], cfg_set[p][3]);
            // fresh pose so later measurements see this phase's rows
            for (int r = 0; r < 3; r++)
                send_item(rjh_pkg::KIND_POSE, rand_item(2'(r)), 0, 0);
            for (int n = 0; n < RAND_ITEMS; n++) begin
                pick = $urandom_range(0, 19);
                if (pick < 4)
                    send_item(rjh_pkg::KIND_POSE, rand_item(2'($urandom_range(0, 2))), 0, 0);
                else if (pick == 4)
                    send_item(rjh_pkg::KIND_POSE, rand_item(2'd3), 0, 0);
                else
                    send_item(rjh_pkg::KIND_MEAS, rand_item(2'($urandom_range(0, 3))), 0, 0);
            end
        end

        drain_results();
        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
src/rjh_pkg.sv
src/rjh_div.sv
src/rjh_sqrt.sv
src/rjh_dp.sv
src/rjh_ctrl.sv
src/reprojection_jacobian_huber.sv
verif/tb.sv
